>>> hdl/stg_pkg.sv
// Shared types, constants and helper functions of the square tone generator.
// No dependencies; every other file of the block uses this package.
package stg_pkg;

	localparam int unsigned CLOCK_HZ = 8000000;
	localparam int NUM_W = $clog2(CLOCK_HZ + 1);
	localparam int TOP_W = 16;
	localparam int FREQ_W = 24;
	localparam int HI_W = NUM_W - TOP_W;
	localparam int PCNT_W = 10;
	localparam int PDIV_W = PCNT_W + 1;
	localparam logic [NUM_W-1:0] CLK_NUM = NUM_W'(CLOCK_HZ);

	localparam logic [7:0] NO_PIN = 8'd255;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_STOP = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	localparam logic [1:0] K_NONE = 2'd0;
	localparam logic [1:0] K_START = 2'd1;
	localparam logic [1:0] K_STOP = 2'd2;
	localparam logic [1:0] K_TICK = 2'd3;

	localparam logic [2:0] PS_OFF = 3'd0;
	localparam logic [2:0] PS_1 = 3'd1;
	localparam logic [2:0] PS_8 = 3'd2;
	localparam logic [2:0] PS_64 = 3'd3;
	localparam logic [2:0] PS_256 = 3'd4;
	localparam logic [2:0] PS_1024 = 3'd5;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] pin;
		logic [FREQ_W-1:0] frequency;
		logic [31:0] length_ms;
		logic [31:0] now_ms;
	} stg_in_t;

	typedef struct packed {
		logic tone_level;
		logic pin_driven;
		logic [7:0] active_pin;
		logic [2:0] prescale_code;
		logic [TOP_W-1:0] top_value;
		logic toggled;
		logic tone_ended;
	} stg_out_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] pin;
		logic [FREQ_W-1:0] frequency;
		logic [31:0] length_ms;
		logic [31:0] now_ms;
	} stg_cmd_t;

	typedef struct packed {
		logic start;
		logic [FREQ_W-1:0] frequency;
	} stg_div_req_t;

	typedef struct packed {
		logic busy;
		logic found;
		logic [2:0] code;
		logic [TOP_W-1:0] quot;
	} stg_div_rsp_t;

	function automatic logic [NUM_W-1:0] presc_num(input logic [2:0] code);
		logic [NUM_W-1:0] n;
		unique case (code)
			PS_1: n = CLK_NUM;
			PS_8: n = CLK_NUM >> 3;
			PS_64: n = CLK_NUM >> 6;
			PS_256: n = CLK_NUM >> 8;
			PS_1024: n = CLK_NUM >> 10;
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [PDIV_W-1:0] presc_div(input logic [2:0] code);
		logic [PDIV_W-1:0] d;
		unique case (code)
			PS_1: d = PDIV_W'(1);
			PS_8: d = PDIV_W'(8);
			PS_64: d = PDIV_W'(64);
			PS_256: d = PDIV_W'(256);
			PS_1024: d = PDIV_W'(1024);
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

>>> hdl/stg_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
// Depends on stg_pkg.
module stg_front (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input stg_pkg::stg_in_t cmd,
	output logic head_valid,
	output stg_pkg::stg_cmd_t head,
	input logic pop
);

	stg_pkg::stg_cmd_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	stg_pkg::stg_cmd_t cls;
	logic push;

	always_comb begin
		cls.pin = cmd.pin;
		cls.frequency = cmd.frequency;
		cls.length_ms = cmd.length_ms;
		cls.now_ms = cmd.now_ms;
		unique case (cmd.mode)
			stg_pkg::MODE_START: begin
				cls.kind = (cmd.frequency == '0) ? stg_pkg::K_STOP : stg_pkg::K_START;
			end
			stg_pkg::MODE_STOP: cls.kind = stg_pkg::K_STOP;
			stg_pkg::MODE_TICK: cls.kind = stg_pkg::K_TICK;
			default: cls.kind = stg_pkg::K_NONE;
		endcase
	end

	assign cmd_ready = (cnt_q != 2'd2);
	assign push = cmd_valid && cmd_ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> hdl/stg_div.sv
// Iterative prescaler search and divider that derives the timer top from a frequency.
// One prescaler is tried per cycle, then one quotient bit is produced per cycle.
// Depends on stg_pkg.
module stg_div (
	input logic clk,
	input logic arst_n,
	input stg_pkg::stg_div_req_t req,
	output stg_pkg::stg_div_rsp_t rsp
);

	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_SEL = 2'd1;
	localparam logic [1:0] DV_DIV = 2'd2;
	localparam int CNT_W = $clog2(stg_pkg::NUM_W + 1);

	logic [1:0] state_q;
	logic [2:0] code_q;
	logic [stg_pkg::FREQ_W-1:0] fq_q;
	logic [stg_pkg::NUM_W-1:0] num_q;
	logic [stg_pkg::FREQ_W-1:0] rem_q;
	logic [stg_pkg::NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic found_q;

	logic [stg_pkg::NUM_W-1:0] num_sel;
	logic [stg_pkg::HI_W-1:0] sel_hi;
	logic fits;
	logic [stg_pkg::FREQ_W:0] shifted;
	logic [stg_pkg::FREQ_W:0] diff;
	logic ge;

	always_comb begin
		num_sel = stg_pkg::presc_num(code_q);
		sel_hi = num_sel[stg_pkg::NUM_W-1:stg_pkg::TOP_W];
		fits = ({{(stg_pkg::FREQ_W - stg_pkg::HI_W){1'b0}}, sel_hi} < fq_q);
		shifted = {rem_q, num_q[stg_pkg::NUM_W-1]};
		diff = shifted - {1'b0, fq_q};
		ge = (shifted >= {1'b0, fq_q});
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			fq_q <= req.frequency;
		end else if (state_q == DV_SEL && fits) begin
			num_q <= num_sel;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == DV_DIV) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[stg_pkg::FREQ_W-1:0] : shifted[stg_pkg::FREQ_W-1:0];
			quo_q <= {quo_q[stg_pkg::NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			code_q <= stg_pkg::PS_OFF;
			cnt_q <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				DV_IDLE: begin
					if (req.start) begin
						state_q <= DV_SEL;
						code_q <= stg_pkg::PS_1;
						found_q <= 1'b0;
					end
				end
				DV_SEL: begin
					if (fits) begin
						state_q <= DV_DIV;
						found_q <= 1'b1;
						cnt_q <= CNT_W'(stg_pkg::NUM_W);
					end else if (code_q == stg_pkg::PS_1024) begin
						state_q <= DV_IDLE;
					end else begin
						code_q <= code_q + 3'd1;
					end
				end
				DV_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= DV_IDLE;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	assign rsp.busy = (state_q != DV_IDLE);
	assign rsp.found = found_q;
	assign rsp.code = code_q;
	assign rsp.quot = quo_q[stg_pkg::TOP_W-1:0];

endmodule

>>> hdl/stg_back.sv
// Back end: holds the tone and timer state, executes queued words and registers the results.
// Depends on stg_pkg and uses stg_div for the top computation of a new tone.
module stg_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input stg_pkg::stg_cmd_t head,
	output logic pop,
	output logic res_valid,
	input logic res_ready,
	output stg_pkg::stg_out_t res
);

	localparam logic BK_RUN = 1'b0;
	localparam logic BK_WAIT = 1'b1;

	logic state_q;
	logic [stg_pkg::FREQ_W-1:0] held_freq_q;
	logic [31:0] duration_q;
	logic [31:0] start_time_q;
	logic [7:0] cur_pin_q;
	logic wrap_en_q;
	logic [2:0] psel_q;
	logic [stg_pkg::TOP_W-1:0] top_q;
	logic [stg_pkg::TOP_W-1:0] tcount_q;
	logic [stg_pkg::PCNT_W-1:0] pcount_q;
	logic level_q;
	logic res_valid_q;
	stg_pkg::stg_out_t res_q;

	stg_pkg::stg_div_req_t div_req;
	stg_pkg::stg_div_rsp_t div_rsp;

	logic can_emit;
	logic same_tone;
	logic need_div;
	logic fire;
	logic [stg_pkg::FREQ_W-1:0] n_held_freq;
	logic [31:0] n_duration;
	logic [31:0] n_start_time;
	logic [7:0] n_cur_pin;
	logic n_wrap_en;
	logic [2:0] n_psel;
	logic [stg_pkg::TOP_W-1:0] n_top;
	logic [stg_pkg::TOP_W-1:0] n_tcount;
	logic [stg_pkg::PCNT_W-1:0] n_pcount;
	logic n_level;
	logic n_toggled;
	logic n_ended;
	logic [stg_pkg::PDIV_W-1:0] pdiv;
	logic [stg_pkg::PDIV_W-1:0] pinc;
	logic [31:0] elapsed;

	stg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign can_emit = !res_valid_q || res_ready;
	assign same_tone = (head.pin == cur_pin_q) && (head.frequency == held_freq_q);
	assign need_div = head_valid && (head.kind == stg_pkg::K_START) && !same_tone;

	always_comb begin
		fire = 1'b0;
		div_req.start = 1'b0;
		div_req.frequency = head.frequency;
		if (state_q == BK_WAIT) begin
			fire = !div_rsp.busy && can_emit;
		end else if (need_div) begin
			div_req.start = 1'b1;
		end else begin
			fire = head_valid && can_emit;
		end
	end

	assign pop = fire;

	always_comb begin
		n_held_freq = held_freq_q;
		n_duration = duration_q;
		n_start_time = start_time_q;
		n_cur_pin = cur_pin_q;
		n_wrap_en = wrap_en_q;
		n_psel = psel_q;
		n_top = top_q;
		n_tcount = tcount_q;
		n_pcount = pcount_q;
		n_level = level_q;
		n_toggled = 1'b0;
		n_ended = 1'b0;
		pdiv = stg_pkg::presc_div(psel_q);
		pinc = {1'b0, pcount_q} + stg_pkg::PDIV_W'(1);
		elapsed = head.now_ms - start_time_q;
		if (state_q == BK_WAIT) begin
			n_held_freq = head.frequency;
			n_duration = head.length_ms;
			if (div_rsp.found) begin
				n_cur_pin = head.pin;
				n_tcount = '0;
				n_pcount = '0;
				n_top = div_rsp.quot;
				n_wrap_en = 1'b1;
				n_level = 1'b1;
				n_start_time = head.now_ms;
				n_psel = div_rsp.code;
			end
		end else begin
			unique case (head.kind)
				stg_pkg::K_START: n_duration = head.length_ms;
				stg_pkg::K_STOP: begin
					n_ended = wrap_en_q;
					n_wrap_en = 1'b0;
					n_cur_pin = stg_pkg::NO_PIN;
				end
				stg_pkg::K_TICK: begin
					if (pdiv != '0) begin
						if (pinc >= pdiv) begin
							n_pcount = '0;
							if (tcount_q >= top_q) begin
								n_tcount = '0;
								if (wrap_en_q) begin
									n_level = !level_q;
									n_toggled = 1'b1;
									if (duration_q != '0 && elapsed >= duration_q) begin
										n_ended = 1'b1;
										n_wrap_en = 1'b0;
										n_cur_pin = stg_pkg::NO_PIN;
									end
								end
							end else begin
								n_tcount = tcount_q + stg_pkg::TOP_W'(1);
							end
						end else begin
							n_pcount = pinc[stg_pkg::PCNT_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			held_freq_q <= '0;
			duration_q <= '0;
			start_time_q <= '0;
			cur_pin_q <= stg_pkg::NO_PIN;
			wrap_en_q <= 1'b0;
			psel_q <= stg_pkg::PS_OFF;
			top_q <= '0;
			tcount_q <= '0;
			pcount_q <= '0;
			level_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (div_req.start) begin
				state_q <= BK_WAIT;
			end else if (fire) begin
				state_q <= BK_RUN;
			end
			if (fire) begin
				held_freq_q <= n_held_freq;
				duration_q <= n_duration;
				start_time_q <= n_start_time;
				cur_pin_q <= n_cur_pin;
				wrap_en_q <= n_wrap_en;
				psel_q <= n_psel;
				top_q <= n_top;
				tcount_q <= n_tcount;
				pcount_q <= n_pcount;
				level_q <= n_level;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.tone_level <= n_level;
			res_q.pin_driven <= (n_cur_pin != stg_pkg::NO_PIN);
			res_q.active_pin <= n_cur_pin;
			res_q.prescale_code <= n_psel;
			res_q.top_value <= n_top;
			res_q.toggled <= n_toggled;
			res_q.tone_ended <= n_ended;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

>>> hdl/square_tone_generator_core.sv
// Top level of the square tone generator: front end queue plus execution back end.
// Depends on stg_pkg, stg_front and stg_back (which holds stg_div).
//
// Each accepted word yields exactly one result word. Ticks, stops, repeated starts of the
// same tone and unused modes need no divider run, so ticks stream at one word per cycle
// while results are taken. A start that changes pin or frequency runs the iterative
// prescaler search and divider: it is launched, tries the prescalers in turn (up to five),
// then, when a prescaler fits, produces one quotient bit per bit of the clock constant
// (23 at 8 MHz), and finally commits. Words arriving meanwhile wait in a two-word
// queue, and the result register lets the next word be taken while a result is still
// pending.
module square_tone_generator_core (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input stg_pkg::stg_in_t cmd,
	output logic res_valid,
	input logic res_ready,
	output stg_pkg::stg_out_t res
);

	logic head_valid;
	stg_pkg::stg_cmd_t head;
	logic pop;

	stg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.head_valid(head_valid),
		.head(head),
		.pop(pop)
	);

	stg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

endmodule

>>> bench/square_tone_generator_core_tb.sv
// Testbench for square_tone_generator_core: directed and random start, stop and tick words.
// Depends on stg_pkg and the block; a built-in tone predictor checks every result word.
`timescale 1ns / 1ps

module square_tone_generator_core_tb;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned RUN_LIMIT = 600000;
	localparam int unsigned WORK_TARGET = 1300;

	typedef struct {
		stg_pkg::stg_in_t word;
		bit drain_first;
	} pending_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	stg_pkg::stg_in_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	stg_pkg::stg_out_t res;

	pending_t pending_words[$];
	stg_pkg::stg_out_t predicted_results[$];
	int unsigned queued_n = 0;
	int unsigned work_n = 0;
	int unsigned taken_n = 0;
	int unsigned errors = 0;
	int unsigned cycle_n = 0;
	logic tail = 1'b0;

	logic [23:0] tn_freq = '0;
	logic [31:0] tn_dur = '0;
	logic [31:0] tn_t0 = '0;
	logic [7:0] tn_pin = stg_pkg::NO_PIN;
	bit tn_run = 1'b0;
	logic [2:0] tn_psel = stg_pkg::PS_OFF;
	logic [15:0] tn_top = '0;
	logic [15:0] tn_cnt = '0;
	logic [10:0] tn_pcnt = '0;
	logic tn_level = 1'b0;

	square_tone_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned prescale_ratio(input logic [2:0] code);
		case (code)
			stg_pkg::PS_1: return 1;
			stg_pkg::PS_8: return 8;
			stg_pkg::PS_64: return 64;
			stg_pkg::PS_256: return 256;
			stg_pkg::PS_1024: return 1024;
			default: return 0;
		endcase
	endfunction

	function automatic bit halt_tone();
		bit was_running;
		was_running = tn_run;
		tn_run = 1'b0;
		tn_pin = stg_pkg::NO_PIN;
		return was_running;
	endfunction

	function automatic stg_pkg::stg_out_t predict_tone_result(input stg_pkg::stg_in_t w);
		stg_pkg::stg_out_t r;
		logic [2:0] code;
		int unsigned quot;
		int unsigned ratio;
		logic [31:0] elapsed;
		bit found;
		bit ended;
		bit wrapped;
		ended = 1'b0;
		wrapped = 1'b0;
		case (w.mode)
			stg_pkg::MODE_START: begin
				if (w.frequency == 0) begin
					ended = halt_tone();
				end else begin
					tn_dur = w.length_ms;
					if (!(w.pin == tn_pin && w.frequency == tn_freq)) begin
						tn_freq = w.frequency;
						found = 1'b0;
						code = stg_pkg::PS_1;
						quot = 0;
						while (!found && code <= stg_pkg::PS_1024) begin
							quot = (stg_pkg::CLOCK_HZ / prescale_ratio(code)) / w.frequency;
							if (quot <= 65535)
								found = 1'b1;
							else
								code = code + 3'd1;
						end
						if (found) begin
							tn_pin = w.pin;
							tn_cnt = '0;
							tn_pcnt = '0;
							tn_top = quot[15:0];
							tn_run = 1'b1;
							tn_level = 1'b1;
							tn_t0 = w.now_ms;
							tn_psel = code;
						end
					end
				end
			end
			stg_pkg::MODE_STOP: begin
				ended = halt_tone();
			end
			stg_pkg::MODE_TICK: begin
				ratio = prescale_ratio(tn_psel);
				if (ratio != 0) begin
					tn_pcnt = tn_pcnt + 11'd1;
					if (tn_pcnt >= ratio) begin
						tn_pcnt = '0;
						if (tn_cnt >= tn_top) begin
							tn_cnt = '0;
							if (tn_run) begin
								tn_level = ~tn_level;
								wrapped = 1'b1;
								elapsed = w.now_ms - tn_t0;
								if (tn_dur != 0 && elapsed >= tn_dur)
									ended = halt_tone();
							end
						end else begin
							tn_cnt = tn_cnt + 16'd1;
						end
					end
				end
			end
			default: ;
		endcase
		r.tone_level = tn_level;
		r.pin_driven = (tn_pin != stg_pkg::NO_PIN);
		r.active_pin = tn_pin;
		r.prescale_code = tn_psel;
		r.top_value = tn_top;
		r.toggled = wrapped;
		r.tone_ended = ended;
		return r;
	endfunction

	task automatic queue_word(input logic [1:0] m, input logic [7:0] p, input logic [23:0] f,
			input logic [31:0] l, input logic [31:0] t, input bit d);
		pending_t e;
		e.word.mode = m;
		e.word.pin = p;
		e.word.frequency = f;
		e.word.length_ms = l;
		e.word.now_ms = t;
		e.drain_first = d;
		pending_words.push_back(e);
		queued_n++;
		if (m != MODE_UNUSED)
			work_n++;
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// Sender.
	int unsigned gap_left = 0;
	pending_t next_e;
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				predicted_results.push_back(predict_tone_result(cmd));
				taken_n++;
			end
			tail <= (pending_words.size() < 150);
			if (!(cmd_valid && !cmd_ready)) begin
				if (gap_left != 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (pending_words.size() == 0) begin
					cmd_valid <= 1'b0;
				end else if (pending_words[0].drain_first && predicted_results.size() != 0) begin
					cmd_valid <= 1'b0;
				end else if (!tail && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(1, 8) - 1;
					cmd_valid <= 1'b0;
				end else begin
					next_e = pending_words.pop_front();
					cmd <= next_e.word;
					cmd_valid <= 1'b1;
				end
			end
		end
	end

	// Receiver and result checker.
	int unsigned got_n = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	bit held = 1'b0;
	stg_pkg::stg_out_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				got_n++;
				if (predicted_results.size() == 0) begin
					errors++;
					$display("%0t: result word with none expected, actual %0h", $time, res);
				end else begin
					want = predicted_results.pop_front();
					compare_field("tone_level", 32'(want.tone_level), 32'(res.tone_level));
					compare_field("pin_driven", 32'(want.pin_driven), 32'(res.pin_driven));
					compare_field("active_pin", 32'(want.active_pin), 32'(res.active_pin));
					compare_field("prescale_code", 32'(want.prescale_code),
						32'(res.prescale_code));
					compare_field("top_value", 32'(want.top_value), 32'(res.top_value));
					compare_field("toggled", 32'(want.toggled), 32'(res.toggled));
					compare_field("tone_ended", 32'(want.tone_ended), 32'(res.tone_ended));
				end
			end
			if (got_n == 300 && !held) begin
				held = 1'b1;
				hold_left = 150;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (!tail && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n == RUN_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] now_r;
		logic [7:0] pin_r;
		logic [7:0] last_pin;
		logic [23:0] freq_r;
		logic [23:0] last_freq;
		logic [31:0] len_r;
		bit same;
		int pick;
		int n;

		queue_word(stg_pkg::MODE_TICK, 8'd0, 24'd0, 32'd0, 32'd0, 1'b0);
		queue_word(MODE_UNUSED, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		queue_word(stg_pkg::MODE_STOP, 8'd0, 24'd0, 32'd0, 32'd1, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd0, 24'd1, 32'd0, 32'd10, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd0, 24'd1, 32'd5, 32'd11, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd3, 24'd15, 32'd0, 32'd12, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd3, 24'd16, 32'd0, 32'd13, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd3, 24'd122, 32'd0, 32'd14, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd3, 24'd123, 32'd0, 32'd15, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		queue_word(stg_pkg::MODE_TICK, 8'd0, 24'd0, 32'd0, 32'd16, 1'b0);
		queue_word(stg_pkg::MODE_TICK, 8'd0, 24'd0, 32'd0, 32'd17, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd5, 24'd0, 32'd0, 32'd18, 1'b0);
		queue_word(stg_pkg::MODE_TICK, 8'd0, 24'd0, 32'd0, 32'd19, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd7, 24'd4000000, 32'd3, 32'd100, 1'b1);
		for (int i = 1; i <= 6; i++)
			queue_word(stg_pkg::MODE_TICK, 8'd0, 24'd0, 32'd0, 32'(32'd100 + i), 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd9, 24'd8000000, 32'd2, 32'hFFFFFFFE, 1'b0);
		queue_word(stg_pkg::MODE_TICK, 8'd0, 24'd0, 32'd0, 32'hFFFFFFFF, 1'b0);
		queue_word(stg_pkg::MODE_TICK, 8'd0, 24'd0, 32'd0, 32'd0, 1'b0);
		queue_word(stg_pkg::MODE_TICK, 8'd0, 24'd0, 32'd0, 32'd1, 1'b0);
		queue_word(stg_pkg::MODE_START, 8'd20, 24'd1000000, 32'd0, 32'd2, 1'b0);
		queue_word(stg_pkg::MODE_STOP, 8'hFF, 24'd0, 32'd0, 32'd3, 1'b0);

		now_r = 32'd1000;
		last_pin = 8'd0;
		last_freq = 24'd0;
		while (work_n < WORK_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				same = (last_freq != 0) && ($urandom_range(0, 5) == 0);
				pin_r = ($urandom_range(0, 9) == 0) ? stg_pkg::NO_PIN :
					8'($urandom_range(0, 254));
				case ($urandom_range(0, 9))
					0: freq_r = 24'($urandom_range(1, 200000));
					1: freq_r = 24'($urandom_range(1, 130));
					default: freq_r = 24'($urandom_range(200000, 24'hFFFFFF));
				endcase
				if (same) begin
					pin_r = last_pin;
					freq_r = last_freq;
				end
				case ($urandom_range(0, 3))
					0: len_r = 32'd0;
					1: len_r = $urandom();
					default: len_r = $urandom_range(1, 8);
				endcase
				last_pin = pin_r;
				last_freq = freq_r;
				queue_word(stg_pkg::MODE_START, pin_r, freq_r, len_r, now_r,
					$urandom_range(0, 24) == 0);
				n = $urandom_range(4, 40);
				repeat (n) begin
					now_r = now_r + $urandom_range(0, 1);
					queue_word(stg_pkg::MODE_TICK, 8'($urandom()), 24'($urandom()), $urandom(),
						now_r, 1'b0);
				end
			end else if (pick < 80) begin
				if ($urandom_range(0, 1) == 0)
					queue_word(stg_pkg::MODE_STOP, 8'($urandom()), 24'($urandom()), $urandom(),
						now_r, 1'b0);
				else
					queue_word(stg_pkg::MODE_START, 8'($urandom()), 24'd0, $urandom(), now_r,
						1'b0);
			end else if (pick < 90) begin
				queue_word(2'($urandom_range(0, 3)), 8'($urandom()), 24'($urandom()), $urandom(),
					$urandom(), 1'b0);
			end else begin
				now_r = now_r + $urandom();
				n = $urandom_range(2, 12);
				repeat (n)
					queue_word(stg_pkg::MODE_TICK, 8'($urandom()), 24'($urandom()), $urandom(),
						now_r, 1'b0);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (taken_n != queued_n)
			@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> square_tone_generator_core.f
hdl/stg_pkg.sv
hdl/stg_front.sv
hdl/stg_div.sv
hdl/stg_back.sv
hdl/square_tone_generator_core.sv
bench/square_tone_generator_core_tb.sv
